### sv/aabb_pkg.sv
package aabb_pkg;

	// Field and datapath widths.
	localparam int COORD_W  = 32;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = 2 * COORD_W;
	localparam int RND_W    = PROD_W - FRAC_W;
	localparam int SUM_W    = RND_W + 2;
	localparam int NUM_AXES = 3;
	localparam int NUM_REGS = 6;
	localparam int REG_W    = 64;
	localparam int CFG_IDX_W = 3;
	localparam int BOX_W    = 2 * NUM_AXES * COORD_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [RND_W-1:0]   rnd_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [REG_W-1:0]          cfg_reg_t;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW0_COLS01 = 3'd0,
		CFG_ROW0_COLS23 = 3'd1,
		CFG_ROW1_COLS01 = 3'd2,
		CFG_ROW1_COLS23 = 3'd3,
		CFG_ROW2_COLS01 = 3'd4,
		CFG_ROW2_COLS23 = 3'd5
	} cfg_idx_t;

	// Identity matrix after reset; 1.0 in Q16.16 is 2^16.
	localparam cfg_reg_t CFG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000
	};

	localparam prod_t ROUND_BIAS = prod_t'(64'sd32768);

	// Q32.32 product to Q32.16, round to nearest with ties towards plus infinity.
	function automatic rnd_t round_prod(input prod_t p);
		prod_t t;
		t = p + ROUND_BIAS;
		return t[PROD_W-1:FRAC_W];
	endfunction

	// Clamp a wide sum to the signed 32-bit range.
	function automatic coord_t sat_coord(input sum_t v);
		coord_t r;
		if ((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1])) begin
			r = v[COORD_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

### sv/aabb_affine_transform_unit.sv
// Four-stage pipeline: multiply, round and min/max, sum, saturate.
// Throughput: one box per cycle; a new box is taken in every cycle while the output drains.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the identity matrix.
module aabb_affine_transform_unit
	import aabb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Input boxes. tdata: lo_x, lo_y, lo_z, hi_x, hi_y, hi_z (32 bits each, lowest first).
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [BOX_W-1:0]     s_axis_tdata,
	// Result boxes. tdata: out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [BOX_W-1:0]     m_axis_tdata,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	cfg_reg_t cfg_q [NUM_REGS];
	coord_t   coef [NUM_AXES][NUM_AXES+1];
	coord_t   lo_in [NUM_AXES];
	coord_t   hi_in [NUM_AXES];

	logic     v_s1, v_s2, v_s3, v_s4;
	logic     en_s1, en_s2, en_s3, en_s4;

	prod_t    prod_lo_s1 [NUM_AXES][NUM_AXES];
	prod_t    prod_hi_s1 [NUM_AXES][NUM_AXES];
	rnd_t     min_s2 [NUM_AXES][NUM_AXES];
	rnd_t     max_s2 [NUM_AXES][NUM_AXES];
	sum_t     sum_lo_s3 [NUM_AXES];
	sum_t     sum_hi_s3 [NUM_AXES];
	coord_t   out_lo_s4 [NUM_AXES];
	coord_t   out_hi_s4 [NUM_AXES];

	// Configuration registers; writes to indexes past the last register are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= CFG_RESET[i];
			end
		end else if (cfg_valid && (cfg_index <= CFG_ROW2_COLS23)) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Unpack the matrix coefficients: two per register, the lower column in the low half.
	for (genvar r = 0; r < NUM_AXES; r++) begin : g_row
		for (genvar c = 0; c <= NUM_AXES; c++) begin : g_col
			localparam int REG_IDX = 2 * r + (c >> 1);
			if (c % 2 == 1) begin : g_hi_half
				assign coef[r][c] = cfg_q[REG_IDX][REG_W-1:COORD_W];
			end else begin : g_lo_half
				assign coef[r][c] = cfg_q[REG_IDX][COORD_W-1:0];
			end
		end
	end

	// Unpack the input corners.
	for (genvar c = 0; c < NUM_AXES; c++) begin : g_in
		assign lo_in[c] = s_axis_tdata[c*COORD_W +: COORD_W];
		assign hi_in[c] = s_axis_tdata[(c+NUM_AXES)*COORD_W +: COORD_W];
	end

	// Stage enables: a stage moves when it is empty or the stage after it moves.
	assign en_s4         = !v_s4 || m_axis_tready;
	assign en_s3         = !v_s3 || en_s4;
	assign en_s2         = !v_s2 || en_s3;
	assign en_s1         = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Stage 1: each coefficient times the low and the high coordinate of its column.
	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			for (int r = 0; r < NUM_AXES; r++) begin
				for (int c = 0; c < NUM_AXES; c++) begin
					prod_lo_s1[r][c] <= prod_t'(coef[r][c]) * prod_t'(lo_in[c]);
					prod_hi_s1[r][c] <= prod_t'(coef[r][c]) * prod_t'(hi_in[c]);
				end
			end
		end
	end

	// Stage 2: round both products and sort them into the smaller and the larger.
	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			for (int r = 0; r < NUM_AXES; r++) begin
				for (int c = 0; c < NUM_AXES; c++) begin
					if (round_prod(prod_lo_s1[r][c]) < round_prod(prod_hi_s1[r][c])) begin
						min_s2[r][c] <= round_prod(prod_lo_s1[r][c]);
						max_s2[r][c] <= round_prod(prod_hi_s1[r][c]);
					end else begin
						min_s2[r][c] <= round_prod(prod_hi_s1[r][c]);
						max_s2[r][c] <= round_prod(prod_lo_s1[r][c]);
					end
				end
			end
		end
	end

	// Stage 3: add the translation to the per-row sums of minima and of maxima.
	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			for (int r = 0; r < NUM_AXES; r++) begin
				sum_lo_s3[r] <= sum_t'(coef[r][NUM_AXES]) + sum_t'(min_s2[r][0])
					+ sum_t'(min_s2[r][1]) + sum_t'(min_s2[r][2]);
				sum_hi_s3[r] <= sum_t'(coef[r][NUM_AXES]) + sum_t'(max_s2[r][0])
					+ sum_t'(max_s2[r][1]) + sum_t'(max_s2[r][2]);
			end
		end
	end

	// Stage 4: saturate into the output register.
	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			for (int r = 0; r < NUM_AXES; r++) begin
				out_lo_s4[r] <= sat_coord(sum_lo_s3[r]);
				out_hi_s4[r] <= sat_coord(sum_hi_s3[r]);
			end
		end
	end

	// Pack the result.
	assign m_axis_tvalid = v_s4;
	for (genvar r = 0; r < NUM_AXES; r++) begin : g_out
		assign m_axis_tdata[r*COORD_W +: COORD_W]            = out_lo_s4[r];
		assign m_axis_tdata[(r+NUM_AXES)*COORD_W +: COORD_W] = out_hi_s4[r];
	end

`ifndef NO_ASSERTIONS
	// The bounding box that leaves the block is never inverted.
	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_lo_s4[0] <= out_hi_s4[0]) && (out_lo_s4[1] <= out_hi_s4[1])
			&& (out_lo_s4[2] <= out_hi_s4[2]))
		else $error("result box has a minimum above its maximum");

	// With the output register empty the pipeline can always take a transaction.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while the output stage is empty");

	// An accepted transaction occupies the first stage in the next cycle.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> v_s1)
		else $error("accepted transaction lost at the first stage");

	// A configuration write to CFG_ROW1_COLS23 lands in that register.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && (cfg_index == CFG_ROW1_COLS23)) |=>
			(cfg_q[CFG_ROW1_COLS23] == $past(cfg_data)))
		else $error("configuration write not stored");
`endif

endmodule
